>>> design/lmcfs_pkg.sv
// lmcfs_pkg: shared types and constants of the led matrix chain frame sender
// depends on nothing; used by every module of the block
package lmcfs_pkg;

   localparam int MAX_MODULES = 8;
   localparam int COLUMNS     = 8;
   localparam logic [3:0] CHAIN_RESET = 4'd4;

   localparam logic [1:0] OP_STORE     = 2'd0;
   localparam logic [1:0] OP_REFRESH   = 2'd1;
   localparam logic [1:0] OP_WRITE_ONE = 2'd2;
   localparam logic [1:0] OP_WRITE_ALL = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] module_index;
      logic [3:0] address;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0] word_address;
      logic [7:0] word_data;
      logic       latch_after;
      logic       last;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      logic [1:0] op;
      logic [2:0] module_index;
      logic [3:0] address;
      logic [7:0] value;
      logic [2:0] last_module;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

>>> design/led_matrix_chain_frame_sender_top.sv
// led_matrix_chain_frame_sender_top: front, command queue and back joined up
// depends on lmcfs_pkg, lmcfs_front, lmcfs_queue and lmcfs_back
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall lmcfs_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall lmcfs_pkg::rsp_type
//   csr      in         csr_valid/csr_ready 4-bit chain length
//
// a store writes the frame buffer and gives no words; a refresh gives 8*n words,
// each a frame buffer read then a response load, register writes give n words,
// n being the clamped chain length
// reset clears the frame buffer valid bits at once and sets the chain to 4
// rsp_stall holds the sequencer; req_stall is high while the queue is full
module led_matrix_chain_frame_sender_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lmcfs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lmcfs_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_data
);

   lmcfs_pkg::q_status_type q_status;
   lmcfs_pkg::cmd_type      push_cmd;
   lmcfs_pkg::cmd_type      pop_cmd;
   logic                    push;
   logic                    pop;

   lmcfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   lmcfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_status (q_status)
   );

   lmcfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/lmcfs_front.sv
// lmcfs_front: accepts request items, holds the chain length register,
// drops items that cause nothing and pushes the rest; uses lmcfs_pkg
module lmcfs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lmcfs_pkg::req_type    req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [3:0]            csr_data,
   input  lmcfs_pkg::q_status_type q_status,
   output logic                  push,
   output lmcfs_pkg::cmd_type    push_cmd
);

   logic [3:0] chain_ff, chain_in;
   logic [2:0] last_module;
   logic       keep;

   assign csr_ready = 1'b1;

   always_comb begin
      chain_in = chain_ff;
      if (csr_valid) begin
         chain_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= lmcfs_pkg::CHAIN_RESET;
      end else begin
         chain_ff <= chain_in;
      end
   end

   // zero acts as one module, anything above the maximum as the maximum
   always_comb begin
      if (chain_ff == 4'd0) begin
         last_module = 3'd0;
      end else if (chain_ff > 4'(lmcfs_pkg::MAX_MODULES)) begin
         last_module = 3'(lmcfs_pkg::MAX_MODULES - 1);
      end else begin
         last_module = 3'(chain_ff - 4'd1);
      end
   end

   always_comb begin
      case (req_data.op)
         lmcfs_pkg::OP_STORE: begin
            keep = ({1'b0, req_data.module_index} < 4'(lmcfs_pkg::MAX_MODULES))
                && (req_data.address < 4'(lmcfs_pkg::COLUMNS));
         end
         lmcfs_pkg::OP_WRITE_ONE: begin
            keep = (req_data.module_index <= last_module);
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   assign req_stall = q_status.full;
   assign push      = req_valid && !req_stall && keep;

   always_comb begin
      push_cmd.op           = req_data.op;
      push_cmd.module_index = req_data.module_index;
      push_cmd.address      = req_data.address;
      push_cmd.value        = req_data.value;
      push_cmd.last_module  = last_module;
   end

endmodule

>>> design/lmcfs_queue.sv
// lmcfs_queue: two-entry command queue between front and back
// uses lmcfs_pkg for the command and status types
module lmcfs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lmcfs_pkg::cmd_type      push_cmd,
   input  logic                    pop,
   output lmcfs_pkg::cmd_type      pop_cmd,
   output lmcfs_pkg::q_status_type q_status
);

   lmcfs_pkg::cmd_type q_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign q_status.empty = (cnt_ff == 2'd0);
   assign q_status.full  = (cnt_ff == 2'd2);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_cmd = q_ff[rp_ff];

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

>>> design/lmcfs_back.sv
// lmcfs_back: command sequencer with the frame buffer memory and the
// response register; uses lmcfs_pkg
module lmcfs_back (
   input  logic                    clock,
   input  logic                    reset,
   input  lmcfs_pkg::q_status_type q_status,
   input  lmcfs_pkg::cmd_type      pop_cmd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lmcfs_pkg::rsp_type      rsp_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FETCH = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;

   localparam int DEPTH = lmcfs_pkg::MAX_MODULES * lmcfs_pkg::COLUMNS;

   logic [1:0]         st_ff, st_in;
   lmcfs_pkg::cmd_type cmd_ff, cmd_in;
   logic [2:0]         m_ff, m_in;
   logic [2:0]         c_ff, c_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lmcfs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [7:0] mem_ff [DEPTH];
   logic       vld_ff [DEPTH];
   logic [7:0] rd_data_ff;
   logic       rd_vld_ff;
   logic       rd_en;
   logic       wr_en;
   logic [5:0] wr_addr;
   logic [5:0] rd_addr;

   logic               out_free;
   logic               latch;
   logic               final_word;
   logic [2:0]         target;
   lmcfs_pkg::rsp_type word;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pop     = (st_ff == ST_IDLE) && !q_status.empty;
   assign wr_en   = pop && (pop_cmd.op == lmcfs_pkg::OP_STORE);
   assign wr_addr = {pop_cmd.module_index, pop_cmd.address[2:0]};
   assign rd_en   = (st_ff == ST_FETCH);
   assign rd_addr = {m_ff, c_ff};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= pop_cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // valid bits make never-stored bytes read as zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign latch  = (m_ff == cmd_ff.last_module);
   assign target = cmd_ff.last_module - cmd_ff.module_index;
   assign final_word = latch
      && ((cmd_ff.op != lmcfs_pkg::OP_REFRESH) || (c_ff == 3'(lmcfs_pkg::COLUMNS - 1)));

   always_comb begin
      word.word_address = 4'd0;
      word.word_data    = 8'd0;
      word.latch_after  = latch;
      word.last         = final_word;
      case (cmd_ff.op)
         lmcfs_pkg::OP_REFRESH: begin
            if (rd_vld_ff && (rd_data_ff != 8'd0)) begin
               word.word_address = {1'b0, c_ff} + 4'd1;
               word.word_data    = rd_data_ff;
            end
         end
         lmcfs_pkg::OP_WRITE_ONE: begin
            if (m_ff == target) begin
               word.word_address = cmd_ff.address;
               word.word_data    = cmd_ff.value;
            end
         end
         lmcfs_pkg::OP_WRITE_ALL: begin
            word.word_address = cmd_ff.address;
            word.word_data    = cmd_ff.value;
         end
         default: begin
            word.word_address = 4'd0;
         end
      endcase
   end

   always_comb begin
      st_in        = st_ff;
      cmd_in       = cmd_ff;
      m_in         = m_ff;
      c_in         = c_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (st_ff)
         ST_IDLE: begin
            if (pop && (pop_cmd.op != lmcfs_pkg::OP_STORE)) begin
               cmd_in = pop_cmd;
               m_in   = 3'd0;
               c_in   = 3'd0;
               st_in  = (pop_cmd.op == lmcfs_pkg::OP_REFRESH) ? ST_FETCH : ST_EMIT;
            end
         end
         ST_FETCH: begin
            st_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = word;
               if (final_word) begin
                  st_in = ST_IDLE;
               end else begin
                  if (latch) begin
                     m_in = 3'd0;
                     c_in = c_ff + 3'd1;
                  end else begin
                     m_in = m_ff + 3'd1;
                  end
                  if (cmd_ff.op == lmcfs_pkg::OP_REFRESH) begin
                     st_in = ST_FETCH;
                  end
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      m_ff        <= m_in;
      c_ff        <= c_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench of led_matrix_chain_frame_sender_top
// depends on lmcfs_pkg and the design files; a shadow frame buffer predicts every
// serial word, and each word taken from the rsp channel is compared in order
module tb_top;
   import lmcfs_pkg::*;

   localparam int CLOCK_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 400;
   localparam int PHASES       = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [3:0] csr_data;

   logic [7:0] shadow_columns [MAX_MODULES*COLUMNS];
   logic [3:0] shadow_chain;
   rsp_type    pending_words [$];
   int         mismatch_count;
   int         words_checked;
   int         cycle_count;
   int         cmds_sent [4];
   int         stall_mode;

   led_matrix_chain_frame_sender_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pending_words.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic int chain_in_use();
      int n;
      n = shadow_chain;
      if (n < 1) n = 1;
      if (n > MAX_MODULES) n = MAX_MODULES;
      return n;
   endfunction

   function automatic void push_word(logic [3:0] a, logic [7:0] d, logic l, logic e);
      rsp_type w;
      w.word_address = a;
      w.word_data    = d;
      w.latch_after  = l;
      w.last         = e;
      pending_words.push_back(w);
   endfunction

   function automatic void apply_command(req_type it);
      int n;
      logic [7:0] b;
      n = chain_in_use();
      cmds_sent[it.op]++;
      case (it.op)
         OP_STORE: begin
            // columns past the buffer are dropped silently
            if (it.address < COLUMNS)
               shadow_columns[it.module_index*COLUMNS + it.address] = it.value;
         end
         OP_REFRESH: begin
            for (int c = 0; c < COLUMNS; c++) begin
               for (int m = 0; m < n; m++) begin
                  b = shadow_columns[m*COLUMNS + c];
                  push_word((b != 0) ? 4'(c + 1) : 4'd0, b, m == n - 1,
                            (c == COLUMNS - 1) && (m == n - 1));
               end
            end
         end
         OP_WRITE_ONE: begin
            // target word sits at n-1-index, no-ops fill the rest of the chain
            if (it.module_index < n) begin
               for (int m = 0; m < n; m++) begin
                  if (m == n - 1 - it.module_index)
                     push_word(it.address, it.value, m == n - 1, m == n - 1);
                  else
                     push_word(4'd0, 8'd0, m == n - 1, m == n - 1);
               end
            end
         end
         default: begin
            for (int m = 0; m < n; m++)
               push_word(it.address, it.value, m == n - 1, m == n - 1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_mismatch(string what, logic has_want, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (has_want)
            $display("%0t %s: expected addr %h data %h latch %b last %b, got addr %h data %h latch %b last %b",
                     $realtime, what, want.word_address, want.word_data, want.latch_after,
                     want.last, got.word_address, got.word_data, got.latch_after, got.last);
         else
            $display("%0t %s: nothing expected, got addr %h data %h latch %b last %b",
                     $realtime, what, got.word_address, got.word_data, got.latch_after,
                     got.last);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            note_mismatch("unexpected word", 1'b0, '0, rsp_data);
         end else begin
            want = pending_words.pop_front();
            words_checked++;
            if (rsp_data.word_address !== want.word_address ||
                rsp_data.word_data !== want.word_data ||
                rsp_data.latch_after !== want.latch_after ||
                rsp_data.last !== want.last)
               note_mismatch("word mismatch", 1'b1, want, rsp_data);
         end
      end
   end

   // receiver stall pattern: free running, random, or runs of stall and release
   initial begin
      int run;
      int mode_left;
      run = 0;
      mode_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 250);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 2) == 0);
            default: begin
               if (run == 0) begin
                  rsp_stall = ~rsp_stall;
                  run = rsp_stall ? $urandom_range(1, 6) : $urandom_range(1, 10);
               end
               run--;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- driving

   function automatic req_type make_item(logic [1:0] op, logic [2:0] idx,
                                         logic [3:0] addr, logic [7:0] val);
      req_type it;
      it.op           = op;
      it.module_index = idx;
      it.address      = addr;
      it.value        = val;
      return it;
   endfunction

   task automatic send_item(req_type it);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_command(it);
   endtask

   task automatic pause_req(int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // all words in, then enough cycles for queued stores and ignored items to clear
   task automatic wait_quiet();
      pause_req(1);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_chain(logic [3:0] len);
      wait_quiet();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_chain = len;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type random_item();
      req_type it;
      int pick;
      pick = $urandom_range(0, 99);
      it = make_item(OP_STORE, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
      if (pick < 50) begin
         if ($urandom_range(0, 9) != 0) it.address = 4'($urandom_range(0, COLUMNS - 1));
         if ($urandom_range(0, 3) == 0) it.value = 8'd0;
      end else if (pick < 65) begin
         it.op = OP_REFRESH;
      end else if (pick < 83) begin
         it.op = OP_WRITE_ONE;
      end else begin
         it.op = OP_WRITE_ALL;
      end
      return it;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_reset_refresh();
      // cleared buffer at the reset chain length gives no-ops only
      send_item(make_item(OP_REFRESH, 3'd0, 4'd0, 8'd0));
   endtask

   task automatic test_store_edges();
      send_item(make_item(OP_STORE, 3'd0, 4'd0, 8'hFF));
      send_item(make_item(OP_STORE, 3'd7, 4'd7, 8'h01));
      send_item(make_item(OP_STORE, 3'd3, 4'd8, 8'hAA));
      send_item(make_item(OP_STORE, 3'd5, 4'd15, 8'h55));
      send_item(make_item(OP_STORE, 3'd1, 4'd2, 8'h00));
      send_item(make_item(OP_STORE, 3'd2, 4'd7, 8'h80));
      send_item(make_item(OP_REFRESH, 3'd0, 4'd0, 8'd0));
   endtask

   task automatic test_register_writes();
      send_item(make_item(OP_WRITE_ONE, 3'd0, 4'hF, 8'hFF));
      send_item(make_item(OP_WRITE_ONE, 3'd3, 4'h1, 8'h00));
      // indexes past the chain give no words
      send_item(make_item(OP_WRITE_ONE, 3'd4, 4'h9, 8'h3C));
      send_item(make_item(OP_WRITE_ONE, 3'd7, 4'hA, 8'hC3));
      send_item(make_item(OP_WRITE_ALL, 3'd7, 4'hF, 8'hFF));
      send_item(make_item(OP_WRITE_ALL, 3'd0, 4'h0, 8'h00));
   endtask

   task automatic test_chain_extremes();
      // zero length acts as one module, anything above eight as eight
      write_chain(4'd0);
      send_item(make_item(OP_REFRESH, 3'd0, 4'd0, 8'd0));
      send_item(make_item(OP_WRITE_ONE, 3'd0, 4'hC, 8'h01));
      send_item(make_item(OP_WRITE_ONE, 3'd1, 4'hC, 8'h01));
      write_chain(4'd15);
      send_item(make_item(OP_REFRESH, 3'd0, 4'd0, 8'd0));
      send_item(make_item(OP_WRITE_ONE, 3'd7, 4'hB, 8'h5A));
      send_item(make_item(OP_WRITE_ALL, 3'd2, 4'h9, 8'hA5));
   endtask

   task automatic test_random_traffic();
      logic [3:0] lengths [PHASES];
      int per_phase;
      int sent;
      int burst;
      lengths = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd2, 4'd3, 4'd5, 4'd7,
                  4'($urandom_range(0, 15)), 4'($urandom_range(0, 15))};
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         write_chain(lengths[p]);
         sent = 0;
         while (sent < per_phase) begin
            burst = $urandom_range(1, 10);
            for (int i = 0; i < burst && sent < per_phase; i++) begin
               send_item(random_item());
               sent++;
            end
            if ($urandom_range(0, 3) != 0) pause_req($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = 4'd0;
      shadow_chain = CHAIN_RESET;
      foreach (shadow_columns[i]) shadow_columns[i] = 8'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_refresh();
      test_store_edges();
      test_register_writes();
      test_chain_extremes();
      test_random_traffic();

      wait_quiet();
      $display("sent %0d stores, %0d refreshes, %0d single and %0d broadcast writes",
               cmds_sent[OP_STORE], cmds_sent[OP_REFRESH], cmds_sent[OP_WRITE_ONE],
               cmds_sent[OP_WRITE_ALL]);
      $display("checked %0d words over chain lengths 0 to 15, %0d wrong, %0d cycles",
               words_checked, mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
design/lmcfs_pkg.sv
design/lmcfs_front.sv
design/lmcfs_queue.sv
design/lmcfs_back.sv
design/led_matrix_chain_frame_sender_top.sv
tb/tb_top.sv
